FILE: design/rmdu_pkg.sv
// Shared types and constants for the RV32M multiply/divide pipeline.
// No dependencies; imported by every module of the block.
package rmdu_pkg;

  localparam int XLEN = 32;
  localparam logic [6:0] OPC_MULDIV = 7'b0110011;
  localparam logic [XLEN-1:0] ALL_ONES = '1;

  typedef enum logic [2:0] {
    OP_MUL    = 3'b000,
    OP_MULH   = 3'b001,
    OP_MULHSU = 3'b010,
    OP_MULHU  = 3'b011,
    OP_DIV    = 3'b100,
    OP_DIVU   = 3'b101,
    OP_REM    = 3'b110,
    OP_REMU   = 3'b111
  } op_t;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] src1_value;
    logic [31:0] src2_value;
  } in_t;

  typedef struct packed {
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        write_enable;
    logic        status;
  } out_t;

  // Item as it moves down the pipe.
  typedef struct packed {
    logic [4:0]        rd;
    logic              ok;
    op_t               op;
    logic [XLEN-1:0]   a_raw;
    logic              b_zero;
    logic              qneg;
    logic              rneg;
    logic              mneg;
    logic [XLEN-1:0]   am;
    logic [XLEN-1:0]   bm;
    logic [2*XLEN-1:0] acc;   // product, then {remainder, quotient}
    logic [XLEN-1:0]   mres;
  } pipe_t;

endpackage

FILE: design/rmdu_prep.sv
// Decode and operand magnitude stage.
// Depends on rmdu_pkg.
module rmdu_prep import rmdu_pkg::*; (
  input  in_t   in_i,
  output pipe_t p_o
);
  logic [XLEN-1:0] a, b;
  logic            sa, sb;
  op_t             op;

  always_comb begin
    a  = in_i.src1_value;
    b  = in_i.src2_value;
    op = op_t'(in_i.instruction[14:12]);
    sa = 1'b0;
    sb = 1'b0;
    unique case (op)
      OP_MULH, OP_DIV, OP_REM: begin
        sa = a[XLEN-1];
        sb = b[XLEN-1];
      end
      OP_MULHSU: begin
        sa = a[XLEN-1];
      end
      default: begin
        sa = 1'b0;
      end
    endcase
    p_o.rd     = in_i.instruction[11:7];
    p_o.ok     = (in_i.instruction[6:0] == OPC_MULDIV);
    p_o.op     = op;
    p_o.a_raw  = a;
    p_o.b_zero = (b == '0);
    p_o.qneg   = sa ^ sb;
    p_o.rneg   = sa;
    p_o.mneg   = sa ^ sb;
    p_o.am     = sa ? (~a + 1'b1) : a;
    p_o.bm     = sb ? (~b + 1'b1) : b;
    p_o.acc    = '0;
    p_o.mres   = '0;
  end
endmodule

FILE: design/rmdu_mult.sv
// Two multiply stages: unsigned magnitude product, then sign fix and half select.
// Depends on rmdu_pkg.
module rmdu_mult import rmdu_pkg::*; (
  input  pipe_t prod_i,
  output pipe_t prod_o,
  input  pipe_t fix_i,
  output pipe_t fix_o
);
  logic [2*XLEN-1:0] sp;

  always_comb begin
    prod_o     = prod_i;
    prod_o.acc = prod_i.am * prod_i.bm;
  end

  always_comb begin
    sp    = fix_i.mneg ? (~fix_i.acc + 1'b1) : fix_i.acc;
    fix_o = fix_i;
    fix_o.mres = (fix_i.op == OP_MUL) ? fix_i.acc[XLEN-1:0] : sp[2*XLEN-1:XLEN];
    // seed the divider: remainder zero, dividend magnitude in the low half
    fix_o.acc  = {{XLEN{1'b0}}, fix_i.am};
  end
endmodule

FILE: design/rmdu_div_step.sv
// One restoring-division step: one quotient bit per stage.
// Depends on rmdu_pkg.
module rmdu_div_step import rmdu_pkg::*; (
  input  pipe_t p_i,
  output pipe_t p_o
);
  logic [XLEN:0] rem_s, diff;
  logic          qbit;

  always_comb begin
    rem_s = {p_i.acc[2*XLEN-1:XLEN], p_i.acc[XLEN-1]};
    diff  = rem_s - {1'b0, p_i.bm};
    qbit  = ~diff[XLEN];
    p_o   = p_i;
    p_o.acc = {(qbit ? diff[XLEN-1:0] : rem_s[XLEN-1:0]), p_i.acc[XLEN-2:0], qbit};
  end
endmodule

FILE: design/rmdu_post.sv
// Result select: sign correction, divide-by-zero handling, status.
// Depends on rmdu_pkg.
module rmdu_post import rmdu_pkg::*; (
  input  pipe_t p_i,
  output out_t  o_o
);
  logic [XLEN-1:0] q, r, val;

  always_comb begin
    q = p_i.acc[XLEN-1:0];
    r = p_i.acc[2*XLEN-1:XLEN];
    case (p_i.op)
      OP_DIV:  val = p_i.b_zero ? ALL_ONES : (p_i.qneg ? (~q + 1'b1) : q);
      OP_DIVU: val = p_i.b_zero ? ALL_ONES : q;
      OP_REM:  val = p_i.b_zero ? p_i.a_raw : (p_i.rneg ? (~r + 1'b1) : r);
      OP_REMU: val = p_i.b_zero ? p_i.a_raw : r;
      default: val = p_i.mres;
    endcase
    o_o.dest_index   = p_i.rd;
    o_o.dest_value   = p_i.ok ? val : '0;
    o_o.write_enable = p_i.ok && (p_i.rd != '0);
    o_o.status       = ~p_i.ok;
  end
endmodule

FILE: design/rv32m_multiply_divide_unit_core.sv
// Top level of the RV32M multiply/divide pipeline.
// Depends on rmdu_pkg, rmdu_prep, rmdu_mult, rmdu_div_step, rmdu_post.
//
// Usage:
//   in_valid/in_stall/in_data carry {instruction, src1_value, src2_value}.
//   out_valid/out_stall/out_data carry {dest_index, dest_value,
//   write_enable, status}. A transfer happens when valid is high and stall
//   is low at a rising clk edge.
//   Every instruction takes the same path: decode/magnitude stage, product
//   stage, multiply sign-fix stage, 32 restoring-division stages (one
//   quotient bit each) and the result register. Results leave in input
//   order. Throughput is one instruction per cycle while out_stall is low;
//   each stage holds one item. When the receiver stalls, the output
//   register holds its item and stages behind it keep filling any empty
//   slots; in_stall rises only once every stage is occupied.
//   Reset (rst_n low, synchronous) empties all stages; nothing else is
//   kept between instructions.
module rv32m_multiply_divide_unit_core import rmdu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);
  localparam int S_FIX = 2;
  localparam int NS    = S_FIX + 1 + XLEN;

  pipe_t         pl_r   [NS];
  pipe_t         pl_nxt [NS];
  logic [NS-1:0] v_r;
  logic [NS:0]   adv;
  out_t          out_nxt, out_data_r;
  logic          out_valid_r;

  rmdu_prep u_prep (.in_i(in_data), .p_o(pl_nxt[0]));

  rmdu_mult u_mult (
    .prod_i (pl_r[0]),
    .prod_o (pl_nxt[1]),
    .fix_i  (pl_r[1]),
    .fix_o  (pl_nxt[S_FIX])
  );

  for (genvar k = 0; k < XLEN; k++) begin : g_div
    rmdu_div_step u_step (.p_i(pl_r[S_FIX+k]), .p_o(pl_nxt[S_FIX+1+k]));
  end

  rmdu_post u_post (.p_i(pl_r[NS-1]), .o_o(out_nxt));

  // a stage may load when it is empty or its item moves on
  assign adv[NS] = ~out_valid_r | ~out_stall;
  for (genvar i = 0; i < NS; i++) begin : g_adv
    assign adv[i] = ~v_r[i] | adv[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
      if (adv[NS]) begin
        out_valid_r <= v_r[NS-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (adv[i]) begin
        pl_r[i] <= pl_nxt[i];
      end
    end
    if (adv[NS]) begin
      out_data_r <= out_nxt;
    end
  end

  assign in_stall  = ~adv[0];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // input backs up only when every slot is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&v_r) && out_valid_r && out_stall))
    else $error("input stalled with a free pipeline slot");

  a_status_we: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.status && out_data.write_enable))
    else $error("unsupported opcode flagged as a register write");

  // an item at the end of the pipe reaches the output register when it frees
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NS-1] && !out_valid_r) |=> out_valid_r)
    else $error("last stage item not moved to output register");

endmodule

FILE: sim/rmdu_checker.sv
`timescale 1ns / 100ps
// Checker for the RV32M multiply/divide unit: watches both channels, predicts
// each result from the accepted instruction and compares. Depends on rmdu_pkg.
module rmdu_checker import rmdu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  output int   fail_count,
  output int   pending
);

  out_t awaited_q[$];

  function automatic logic [31:0] magnitude(logic [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

  function automatic out_t execute(in_t item);
    out_t r;
    logic [31:0] a, b, q, m;
    logic [63:0] prod;
    op_t op;
    a = item.src1_value;
    b = item.src2_value;
    op = op_t'(item.instruction[14:12]);
    r.dest_index = item.instruction[11:7];
    r.dest_value = '0;
    r.status = (item.instruction[6:0] != OPC_MULDIV);
    r.write_enable = !r.status && (r.dest_index != 5'd0);
    if (!r.status) begin
      case (op)
        OP_MUL: r.dest_value = a * b;
        OP_MULH: begin
          prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
          r.dest_value = prod[63:32];
        end
        OP_MULHSU: begin
          prod = {{32{a[31]}}, a} * {32'b0, b};
          r.dest_value = prod[63:32];
        end
        OP_MULHU: begin
          prod = {32'b0, a} * {32'b0, b};
          r.dest_value = prod[63:32];
        end
        OP_DIV: begin
          if (b == 0) r.dest_value = ALL_ONES;
          else begin
            q = magnitude(a) / magnitude(b);
            r.dest_value = (a[31] ^ b[31]) ? 32'(-q) : q;
          end
        end
        OP_DIVU: r.dest_value = (b == 0) ? ALL_ONES : a / b;
        OP_REM: begin
          if (b == 0) r.dest_value = a;
          else begin
            m = magnitude(a) % magnitude(b);
            r.dest_value = a[31] ? 32'(-m) : m;
          end
        end
        default: r.dest_value = (b == 0) ? a : a % b;
      endcase
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = awaited_q.size();

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) awaited_q.push_back(execute(in_data));
      if (out_valid && !out_stall) begin
        if (awaited_q.size() == 0) report("unexpected transfer", 32'd0, 32'd0);
        else begin
          want = awaited_q.pop_front();
          if (out_data.dest_index != want.dest_index)
            report("dest_index", 32'(out_data.dest_index), 32'(want.dest_index));
          if (out_data.dest_value != want.dest_value)
            report("dest_value", out_data.dest_value, want.dest_value);
          if (out_data.write_enable != want.write_enable)
            report("write_enable", 32'(out_data.write_enable),
                   32'(want.write_enable));
          if (out_data.status != want.status)
            report("status", 32'(out_data.status), 32'(want.status));
        end
      end
    end
  end

endmodule

FILE: sim/tb_rv32m_multiply_divide_unit_core.sv
`timescale 1ns / 100ps
// Stimulus and verdict for rv32m_multiply_divide_unit_core.
// Depends on rmdu_pkg, the design and rmdu_checker.
module tb_rv32m_multiply_divide_unit_core;
  import rmdu_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_t out_data;
  int   fail_count;
  int   pending;
  int   send_idle = 0;
  int   recv_idle = 0;

  always #2 clk = ~clk;

  rv32m_multiply_divide_unit_core dut (.*);

  rmdu_checker checker_i (.*);

  // receiver stall, rerolled each cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'h80000000;
      2: return 32'hffffffff;
      3: return 32'h7fffffff;
      4: return $urandom_range(15);
      5: return 32'(-$urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic [31:0] insn, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{insn, a, b};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] encode(op_t op, logic [4:0] rd);
    logic [31:0] w;
    w = $urandom;
    w[6:0] = OPC_MULDIV;
    w[14:12] = op;
    w[11:7] = rd;
    return w;
  endfunction

  task automatic random_phase(int count);
    logic [31:0] insn;
    repeat (count) begin
      insn = encode(op_t'(3'($urandom_range(7))), 5'($urandom_range(31)));
      if ($urandom_range(9) == 0) insn = $urandom;
      send(insn, pick_operand(), pick_operand());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // every op on the corner operands, including divide by zero and overflow
    for (int k = 0; k < 8; k++) begin
      send(encode(op_t'(3'(k)), 5'd31), 32'h80000000, 32'hffffffff);
      send(encode(op_t'(3'(k)), 5'd0), 32'hffffffff, 32'h0);
    end
    send(32'hffffffff, 32'h12345678, 32'h9abcdef0);
    send(32'h00000000, 32'hffffffff, 32'hffffffff);
    send(encode(OP_MULHSU, 5'd1), 32'hffffffff, 32'hffffffff);
    send(encode(OP_REM, 5'd2), 32'hfffffff9, 32'h2);
    send(encode(OP_DIV, 5'd3), 32'h7, 32'hfffffffe);
    send_idle = 25;
    recv_idle = 77;
    random_phase(200);
    send_idle = 77;
    recv_idle = 25;
    random_phase(200);
    send_idle = 0;
    recv_idle = 0;
    random_phase(200);
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("rv32m_multiply_divide_unit_core: match");
    else $display("rv32m_multiply_divide_unit_core: mismatch");
    $finish;
  end

  initial begin
    #2000000;
    $display("rv32m_multiply_divide_unit_core: mismatch");
    $finish;
  end

endmodule

FILE: files.f
design/rmdu_pkg.sv
design/rmdu_prep.sv
design/rmdu_mult.sv
design/rmdu_div_step.sv
design/rmdu_post.sv
design/rv32m_multiply_divide_unit_core.sv
sim/rmdu_checker.sv
sim/tb_rv32m_multiply_divide_unit_core.sv
